>>> src/tsbh_pkg.sv
// ----------------------------------------------------------------------------
// tsbh_pkg
// Shared types, command codes and constants for the text statistics core.
// ----------------------------------------------------------------------------
package tsbh_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int OUT_WIDTH       = 32;
    localparam int NUM_BINS        = 256;
    localparam int BIN_AW          = 8;
    localparam int QUEUE_DEPTH     = 2;

    // input modes
    localparam logic [1:0] MODE_DATA  = 2'd0;
    localparam logic [1:0] MODE_END   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // byte values with special meaning
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_VT      = 8'd11;
    localparam logic [7:0] CH_FF      = 8'd12;
    localparam logic [7:0] CH_CR      = 8'd13;

    // command kinds handed from front to back
    localparam logic [2:0] K_BYTE    = 3'd0;
    localparam logic [2:0] K_NEWLINE = 3'd1;
    localparam logic [2:0] K_END     = 3'd2;
    localparam logic [2:0] K_READ    = 3'd3;
    localparam logic [2:0] K_CLEAR   = 3'd4;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic [7:0] bin_index;
    } t_in_word;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] line_count;
        logic [OUT_WIDTH-1:0] word_count;
        logic [OUT_WIDTH-1:0] char_count;
        logic [OUT_WIDTH-1:0] bin_count;
    } t_out_word;

    typedef struct packed {
        logic [2:0]        kind;
        logic              blank;
        logic [BIN_AW-1:0] addr;
    } t_cmd;

endpackage

>>> src/tsbh_front.sv
// ----------------------------------------------------------------------------
// tsbh_front
// Decodes incoming words into commands and holds them in a short queue.
// ----------------------------------------------------------------------------
module tsbh_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  tsbh_pkg::t_in_word i_item,
    input  logic              i_hold,
    output logic              o_cmd_valid,
    output tsbh_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);

    localparam int QD  = tsbh_pkg::QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    tsbh_pkg::t_cmd r_q [QD];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QCW-1:0] r_count;
    tsbh_pkg::t_cmd w_cmd;
    logic           w_push_acc, w_pop_acc;

    always_comb begin
        w_cmd.addr  = i_item.data_byte;
        w_cmd.blank = (i_item.data_byte == tsbh_pkg::CH_SPACE) ||
                      (i_item.data_byte == tsbh_pkg::CH_TAB)   ||
                      (i_item.data_byte == tsbh_pkg::CH_VT)    ||
                      (i_item.data_byte == tsbh_pkg::CH_FF)    ||
                      (i_item.data_byte == tsbh_pkg::CH_CR);
        case (i_item.mode)
            tsbh_pkg::MODE_DATA: begin
                w_cmd.kind = (i_item.data_byte == tsbh_pkg::CH_NEWLINE) ?
                             tsbh_pkg::K_NEWLINE : tsbh_pkg::K_BYTE;
            end
            tsbh_pkg::MODE_END: begin
                w_cmd.kind = tsbh_pkg::K_END;
            end
            tsbh_pkg::MODE_READ: begin
                w_cmd.kind = tsbh_pkg::K_READ;
                w_cmd.addr = i_item.bin_index;
            end
            default: begin
                w_cmd.kind = tsbh_pkg::K_CLEAR;
            end
        endcase
    end

    assign full        = (r_count == QCW'(QD)) || i_hold;
    assign w_push_acc  = push && !full;
    assign o_cmd_valid = (r_count != '0);
    assign w_pop_acc   = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push_acc) begin
            r_q[r_wptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push_acc) begin
                r_wptr <= (r_wptr == QAW'(QD - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop_acc) begin
                r_rptr <= (r_rptr == QAW'(QD - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_push_acc, w_pop_acc})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/tsbh_back.sv
// ----------------------------------------------------------------------------
// tsbh_back
// Executes commands: counters, histogram memory, clear sweep, result register.
// ----------------------------------------------------------------------------
module tsbh_back #(
    parameter int COUNT_WIDTH = tsbh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  tsbh_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_busy,
    output logic                empty,
    input  logic                pop,
    output tsbh_pkg::t_out_word o_result
);

    localparam int OW    = tsbh_pkg::OUT_WIDTH;
    localparam int EXT_W = (COUNT_WIDTH > OW) ? COUNT_WIDTH : OW;
    localparam int AW    = tsbh_pkg::BIN_AW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BUMP  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_SWEEP = 2'd3;

    logic [COUNT_WIDTH-1:0] r_bins [tsbh_pkg::NUM_BINS];

    logic [1:0]             r_state, n_state;
    logic [AW-1:0]          r_ptr, n_ptr;
    logic [AW-1:0]          r_addr, n_addr;
    logic                   r_inside, n_inside;
    logic                   r_open, n_open;
    logic [COUNT_WIDTH-1:0] r_lines, n_lines;
    logic [COUNT_WIDTH-1:0] r_words, n_words;
    logic [COUNT_WIDTH-1:0] r_chars, n_chars;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_out_valid, n_out_valid;
    tsbh_pkg::t_out_word    r_out, n_out;

    logic                   w_rd_en, w_wr_en;
    logic [AW-1:0]          w_rd_addr, w_wr_addr;
    logic [COUNT_WIDTH-1:0] w_wr_data;
    logic                   w_slot_free, w_start;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [OW-1:0] shown(input logic [COUNT_WIDTH-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[OW-1:0];
    endfunction

    assign w_slot_free = !r_out_valid || pop;
    assign w_start     = (r_state == ST_IDLE) && i_cmd_valid && w_slot_free;
    assign o_cmd_pop   = w_start;
    assign o_busy      = (r_state == ST_SWEEP);
    assign empty       = !r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_addr      = r_addr;
        n_inside    = r_inside;
        n_open      = r_open;
        n_lines     = r_lines;
        n_words     = r_words;
        n_chars     = r_chars;
        n_out_valid = r_out_valid && !pop;
        n_out       = r_out;
        w_rd_en     = 1'b0;
        w_rd_addr   = i_cmd.addr;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_addr;
        w_wr_data   = sat_inc(r_rd_data);

        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_addr = i_cmd.addr;
                    case (i_cmd.kind)
                        tsbh_pkg::K_BYTE: begin
                            n_chars = sat_inc(r_chars);
                            n_open  = 1'b1;
                            if (i_cmd.blank) begin
                                n_inside = 1'b0;
                            end else if (!r_inside) begin
                                n_words  = sat_inc(r_words);
                                n_inside = 1'b1;
                            end
                            w_rd_en = 1'b1;
                            n_state = ST_BUMP;
                        end
                        tsbh_pkg::K_NEWLINE: begin
                            n_lines  = sat_inc(r_lines);
                            n_open   = 1'b0;
                            n_inside = 1'b0;
                        end
                        tsbh_pkg::K_END: begin
                            if (r_open) begin
                                n_lines = sat_inc(r_lines);
                            end
                            n_open   = 1'b0;
                            n_inside = 1'b0;
                        end
                        tsbh_pkg::K_READ: begin
                            w_rd_en = 1'b1;
                            n_state = ST_READ;
                        end
                        default: begin
                            n_lines  = '0;
                            n_words  = '0;
                            n_chars  = '0;
                            n_open   = 1'b0;
                            n_inside = 1'b0;
                            n_ptr    = '0;
                            n_state  = ST_SWEEP;
                        end
                    endcase
                    // byte and read results wait for the memory data
                    if (i_cmd.kind != tsbh_pkg::K_BYTE && i_cmd.kind != tsbh_pkg::K_READ) begin
                        n_out_valid       = 1'b1;
                        n_out.line_count  = shown(n_lines);
                        n_out.word_count  = shown(n_words);
                        n_out.char_count  = shown(n_chars);
                        n_out.bin_count   = '0;
                    end
                end
            end
            ST_BUMP: begin
                w_wr_en          = 1'b1;
                n_out_valid      = 1'b1;
                n_out.line_count = shown(r_lines);
                n_out.word_count = shown(r_words);
                n_out.char_count = shown(r_chars);
                n_out.bin_count  = '0;
                n_state          = ST_IDLE;
            end
            ST_READ: begin
                n_out_valid      = 1'b1;
                n_out.line_count = shown(r_lines);
                n_out.word_count = shown(r_words);
                n_out.char_count = shown(r_chars);
                n_out.bin_count  = shown(r_rd_data);
                n_state          = ST_IDLE;
            end
            default: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_ptr;
                w_wr_data = '0;
                n_ptr     = r_ptr + 1'b1;
                if (r_ptr == '1) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_bins[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_bins[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_out  <= n_out;
    end

    // reset starts a clearing pass over the histogram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_ptr       <= '0;
            r_inside    <= 1'b0;
            r_open      <= 1'b0;
            r_lines     <= '0;
            r_words     <= '0;
            r_chars     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_inside    <= n_inside;
            r_open      <= n_open;
            r_lines     <= n_lines;
            r_words     <= n_words;
            r_chars     <= n_chars;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> src/text_stats_byte_histogram_core.sv
// ----------------------------------------------------------------------------
// text_stats_byte_histogram_core
// Line, word and character counts with a 256-bin byte histogram.
// ----------------------------------------------------------------------------
// each result passes the command queue, then the result register; data bytes
//   and bin reads pass the histogram memory read in between
// a histogram word reads memory, then writes back, before the next is taken;
//   newline and end of text go one word per cycle while results are popped
// clear holds full high while a sweep zeroes all 256 histogram bins
// synchronous reset clears counters, runs the same sweep, full high till done
module text_stats_byte_histogram_core #(
    parameter int COUNT_WIDTH = tsbh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  tsbh_pkg::t_in_word  i_item,
    output logic                empty,
    input  logic                pop,
    output tsbh_pkg::t_out_word o_result
);

    logic           w_cmd_valid, w_cmd_pop, w_busy;
    tsbh_pkg::t_cmd w_cmd;

    tsbh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_hold      (w_busy),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    tsbh_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_busy      (w_busy),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule
